### src/ffa_pkg.sv
// Shared types, datapath command codes and result codes of the first-fit arena allocator.
package ffa_pkg;

    localparam int ARENA_BYTES_DEF  = 4096;
    localparam int HEADER_BYTES_DEF = 12;

    localparam int REQ_W  = 12;  // request size and payload offset fields
    localparam int LINK_W = 16;  // next-header link held in a header entry
    localparam int SUM_W  = 18;  // room for offset + header + request + header
    localparam int HDR_W  = LINK_W + 1;
    localparam int ST_W   = 2;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_OOM     = 2'd1;
    localparam logic [ST_W-1:0] ST_NO_FREE = 2'd2;

    typedef logic [3:0] t_dp_cmd;

    localparam t_dp_cmd DC_NONE         = 4'd0;
    localparam t_dp_cmd DC_LOAD         = 4'd1;
    localparam t_dp_cmd DC_RESTART      = 4'd2;
    localparam t_dp_cmd DC_STEP         = 4'd3;
    localparam t_dp_cmd DC_LATCH        = 4'd4;
    localparam t_dp_cmd DC_INIT_EMPTY   = 4'd5;
    localparam t_dp_cmd DC_WR_NEW       = 4'd6;
    localparam t_dp_cmd DC_WR_CUR_NEW   = 4'd7;
    localparam t_dp_cmd DC_WR_CUR_WHOLE = 4'd8;
    localparam t_dp_cmd DC_FREE_HIT     = 4'd9;
    localparam t_dp_cmd DC_MERGE_TAIL   = 4'd10;
    localparam t_dp_cmd DC_MERGE_LINK   = 4'd11;
    localparam t_dp_cmd DC_RES_OOM      = 4'd12;
    localparam t_dp_cmd DC_RES_OK       = 4'd13;
    localparam t_dp_cmd DC_RES_FREE     = 4'd14;
    localparam t_dp_cmd DC_PUBLISH      = 4'd15;

    typedef struct packed {
        logic head_empty;  // chain holds no block yet
        logic stop;        // current link is zero or does not move forward
        logic used;        // current block is taken
        logic fit;         // current free block has room for the request
        logic split;       // leftover exceeds one header
        logic tail_zero;   // current block is the tail
        logic over;        // new tail header would not fit in the arena
        logic match;       // current payload offset equals the free offset
        logic rd_used;     // next block is taken
        logic rd_zero;     // next block is the tail
        logic rd_back;     // next block's link does not move forward
    } t_dp_status;

endpackage

### src/ffa_datapath.sv
// Datapath of the arena allocator: header memory, head header, walk registers, results.
module ffa_datapath
    import ffa_pkg::*;
#(
    parameter int ARENA_BYTES  = ARENA_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [REQ_W-1:0]  i_request_bytes,
    input  logic [REQ_W-1:0]  i_block_offset,
    output t_dp_status        o_dp_status,
    output logic [REQ_W-1:0]  o_payload_offset,
    output logic [ST_W-1:0]   o_status
);

    localparam int AW = $clog2(ARENA_BYTES);
    localparam logic [SUM_W-1:0] HB    = SUM_W'(HEADER_BYTES);
    localparam logic [SUM_W-1:0] ARENA = SUM_W'(ARENA_BYTES);

    logic [HDR_W-1:0]  r_mem [ARENA_BYTES];
    logic [HDR_W-1:0]  r_rdata;
    logic [LINK_W-1:0] r_head, n_head;
    logic [LINK_W-1:0] r_cur, n_cur;
    logic [LINK_W-1:0] r_link, n_link;
    logic              r_used, n_used;
    logic              r_hit, n_hit;
    logic [REQ_W-1:0]  r_size, n_size;
    logic [REQ_W-1:0]  r_off, n_off;
    logic [REQ_W-1:0]  r_res_pay, n_res_pay;
    logic [ST_W-1:0]   r_res_st, n_res_st;
    logic [REQ_W-1:0]  r_out_pay, n_out_pay;
    logic [ST_W-1:0]   r_out_st, n_out_st;

    logic [SUM_W-1:0]  w_pay, w_after, w_new, w_room, w_size;
    logic [LINK_W-1:0] w_rd_link;
    logic              w_wr_en;
    logic [AW-1:0]     w_wr_addr;
    logic [HDR_W-1:0]  w_wr_data;

    assign w_pay     = SUM_W'(r_cur) + HB;
    assign w_after   = SUM_W'(r_link);
    assign w_size    = SUM_W'(r_size);
    assign w_new     = w_pay + w_size;
    assign w_room    = (w_after >= w_pay) ? (w_after - w_pay) : '0;
    assign w_rd_link = r_rdata[LINK_W-1:0];

    assign o_dp_status.head_empty = (r_head == '0);
    assign o_dp_status.stop       = (r_link == '0) || (r_link <= r_cur);
    assign o_dp_status.used       = r_used;
    assign o_dp_status.fit        = (w_room >= w_size);
    assign o_dp_status.split      = ((w_room - w_size) > HB);
    assign o_dp_status.tail_zero  = (r_link == '0);
    assign o_dp_status.over       = ((w_new + HB) > ARENA);
    assign o_dp_status.match      = (w_pay == SUM_W'(r_off));
    assign o_dp_status.rd_used    = r_rdata[LINK_W];
    assign o_dp_status.rd_zero    = (w_rd_link == '0);
    assign o_dp_status.rd_back    = (w_rd_link <= r_link);

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_cur[AW-1:0];
        w_wr_data = {1'b0, r_link};
        case (i_cmd)
            DC_WR_NEW: begin
                w_wr_en   = 1'b1;
                w_wr_addr = w_new[AW-1:0];
                w_wr_data = {1'b0, r_link};
            end
            DC_WR_CUR_NEW: begin
                w_wr_en   = 1'b1;
                w_wr_data = {1'b1, w_new[LINK_W-1:0]};
            end
            DC_WR_CUR_WHOLE: begin
                w_wr_en   = 1'b1;
                w_wr_data = {1'b1, r_link};
            end
            DC_FREE_HIT: begin
                w_wr_en   = 1'b1;
                w_wr_data = {1'b0, r_link};
            end
            DC_MERGE_TAIL: begin
                w_wr_en   = 1'b1;
                w_wr_data = '0;
            end
            DC_MERGE_LINK: begin
                w_wr_en   = 1'b1;
                w_wr_data = {1'b0, w_rd_link};
            end
            default: begin
                w_wr_en = 1'b0;
            end
        endcase
    end

    // Read the entry the current link points at, every cycle.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rdata <= r_mem[r_link[AW-1:0]];
    end

    always_comb begin
        n_head    = r_head;
        n_cur     = r_cur;
        n_link    = r_link;
        n_used    = r_used;
        n_hit     = r_hit;
        n_size    = r_size;
        n_off     = r_off;
        n_res_pay = r_res_pay;
        n_res_st  = r_res_st;
        n_out_pay = r_out_pay;
        n_out_st  = r_out_st;
        case (i_cmd)
            DC_LOAD: begin
                n_size = i_request_bytes;
                n_off  = i_block_offset;
                n_hit  = 1'b0;
                n_cur  = '0;
                n_link = r_head;
                n_used = 1'b0;
            end
            DC_RESTART: begin
                n_cur  = '0;
                n_link = r_head;
                n_used = 1'b0;
            end
            DC_STEP: begin
                n_cur = r_link;
            end
            DC_LATCH: begin
                n_link = w_rd_link;
                n_used = r_rdata[LINK_W];
            end
            DC_INIT_EMPTY: begin
                // first block sits right after the head, acting as a tail
                n_cur  = LINK_W'(HEADER_BYTES);
                n_link = '0;
                n_used = 1'b0;
            end
            DC_WR_CUR_NEW: begin
                if (r_head == '0) begin
                    n_head = r_cur;
                end
            end
            DC_FREE_HIT: begin
                n_used = 1'b0;
                n_hit  = 1'b1;
            end
            DC_MERGE_TAIL: begin
                n_link = '0;
            end
            DC_MERGE_LINK: begin
                n_link = w_rd_link;
            end
            DC_RES_OOM: begin
                n_res_pay = '0;
                n_res_st  = ST_OOM;
            end
            DC_RES_OK: begin
                n_res_pay = w_pay[REQ_W-1:0];
                n_res_st  = ST_OK;
            end
            DC_RES_FREE: begin
                n_res_pay = '0;
                n_res_st  = r_hit ? ST_OK : ST_NO_FREE;
            end
            DC_PUBLISH: begin
                n_out_pay = r_res_pay;
                n_out_st  = r_res_st;
            end
            default: begin
                n_cur = r_cur;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_hit  <= 1'b0;
        end else begin
            r_head <= n_head;
            r_hit  <= n_hit;
        end
        r_cur     <= n_cur;
        r_link    <= n_link;
        r_used    <= n_used;
        r_size    <= n_size;
        r_off     <= n_off;
        r_res_pay <= n_res_pay;
        r_res_st  <= n_res_st;
        r_out_pay <= n_out_pay;
        r_out_st  <= n_out_st;
    end

    assign o_payload_offset = r_out_pay;
    assign o_status         = r_out_st;

endmodule

### src/ffa_controller.sv
// Sequencer of the arena allocator: allocate walk, free search, merge pass, handshakes.
module ffa_controller
    import ffa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_command,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_dp_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_AEMPTY  = 4'd1;
    localparam logic [3:0] S_ASTEP   = 4'd2;
    localparam logic [3:0] S_ALATCH  = 4'd3;
    localparam logic [3:0] S_AEVAL   = 4'd4;
    localparam logic [3:0] S_ASPLIT  = 4'd5;
    localparam logic [3:0] S_ATAIL   = 4'd6;
    localparam logic [3:0] S_AOK     = 4'd7;
    localparam logic [3:0] S_FSTEP   = 4'd8;
    localparam logic [3:0] S_FLATCH  = 4'd9;
    localparam logic [3:0] S_FEVAL   = 4'd10;
    localparam logic [3:0] S_MSTEP   = 4'd11;
    localparam logic [3:0] S_MLATCH  = 4'd12;
    localparam logic [3:0] S_MIN     = 4'd13;
    localparam logic [3:0] S_MN      = 4'd14;
    localparam logic [3:0] S_DONE    = 4'd15;

    localparam logic CMD_ALLOC = 1'b0;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       r_merge_end, n_merge_end;

    always_comb begin
        n_state     = r_state;
        n_merge_end = r_merge_end;
        o_cmd       = DC_NONE;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd = DC_LOAD;
                    if (i_command != CMD_ALLOC) begin
                        n_state = S_FSTEP;
                    end else if (i_dp_status.head_empty) begin
                        n_state = S_AEMPTY;
                    end else begin
                        n_state = S_ASTEP;
                    end
                end
            end
            S_AEMPTY: begin
                o_cmd   = DC_INIT_EMPTY;
                n_state = S_AEVAL;
            end
            S_ASTEP: begin
                if (i_dp_status.stop) begin
                    o_cmd   = DC_RES_OOM;
                    n_state = S_DONE;
                end else begin
                    o_cmd   = DC_STEP;
                    n_state = S_ALATCH;
                end
            end
            S_ALATCH: begin
                o_cmd   = DC_LATCH;
                n_state = S_AEVAL;
            end
            S_AEVAL: begin
                if (i_dp_status.used) begin
                    n_state = S_ASTEP;
                end else if (!i_dp_status.stop) begin
                    if (!i_dp_status.fit) begin
                        n_state = S_ASTEP;
                    end else if (i_dp_status.split) begin
                        o_cmd   = DC_WR_NEW;
                        n_state = S_ASPLIT;
                    end else begin
                        o_cmd   = DC_WR_CUR_WHOLE;
                        n_state = S_AOK;
                    end
                end else if (i_dp_status.tail_zero && !i_dp_status.over) begin
                    o_cmd   = DC_WR_CUR_NEW;
                    n_state = S_ATAIL;
                end else begin
                    o_cmd   = DC_RES_OOM;
                    n_state = S_DONE;
                end
            end
            S_ASPLIT: begin
                o_cmd   = DC_WR_CUR_NEW;
                n_state = S_AOK;
            end
            S_ATAIL: begin
                o_cmd   = DC_WR_NEW;
                n_state = S_AOK;
            end
            S_AOK: begin
                o_cmd   = DC_RES_OK;
                n_state = S_DONE;
            end
            S_FSTEP: begin
                if (i_dp_status.stop) begin
                    o_cmd   = DC_RESTART;
                    n_state = S_MSTEP;
                end else begin
                    o_cmd   = DC_STEP;
                    n_state = S_FLATCH;
                end
            end
            S_FLATCH: begin
                o_cmd   = DC_LATCH;
                n_state = S_FEVAL;
            end
            S_FEVAL: begin
                if (i_dp_status.used && i_dp_status.match) begin
                    // end the search; the merge pass restarts from the head
                    o_cmd       = DC_FREE_HIT;
                    n_state     = S_MSTEP;
                    n_merge_end = 1'b1;
                end else begin
                    n_state = S_FSTEP;
                end
            end
            S_MSTEP: begin
                if (r_merge_end) begin
                    // merge starts from the head after a hit
                    o_cmd       = DC_RESTART;
                    n_merge_end = 1'b0;
                end else if (i_dp_status.stop) begin
                    o_cmd   = DC_RES_FREE;
                    n_state = S_DONE;
                end else begin
                    o_cmd   = DC_STEP;
                    n_state = S_MLATCH;
                end
            end
            S_MLATCH: begin
                o_cmd   = DC_LATCH;
                n_state = S_MIN;
            end
            S_MIN: begin
                // memory fetches the next block during this cycle
                if (i_dp_status.stop || i_dp_status.used) begin
                    n_state = S_MSTEP;
                end else begin
                    n_state = S_MN;
                end
            end
            S_MN: begin
                if (i_dp_status.rd_used) begin
                    n_state = S_MSTEP;
                end else if (i_dp_status.rd_zero) begin
                    // tail reached: the tail write makes the link zero, so
                    // the outer step stops and posts the free result
                    o_cmd   = DC_MERGE_TAIL;
                    n_state = S_MSTEP;
                end else if (i_dp_status.rd_back) begin
                    n_state = S_MSTEP;
                end else begin
                    o_cmd   = DC_MERGE_LINK;
                    n_state = S_MIN;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd   = DC_PUBLISH;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd == DC_PUBLISH) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_merge_end <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_merge_end <= n_merge_end;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### src/first_fit_arena_allocator_top.sv
// First-fit arena allocator: one request in, one word out per request, after a walk of
// the header chain. Each header visited takes a step, a memory read and a check;
// allocate then adds header writes and the result, and free walks the chain once to
// find the block and again to merge adjacent free blocks, with a memory read and a
// check per merged block, so latency follows chain length. The header memory, with
// one write port and a registered read port, sets this pace. The head header lives in
// a register cleared by reset, so no clearing pass is needed. A new request is taken
// while the previous result still waits in the output register.
module first_fit_arena_allocator_top
    import ffa_pkg::*;
#(
    parameter int ARENA_BYTES  = ARENA_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_command,
    input  logic [REQ_W-1:0]  i_request_bytes,
    input  logic [REQ_W-1:0]  i_block_offset,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [REQ_W-1:0]  o_payload_offset,
    output logic [ST_W-1:0]   o_status
);

    t_dp_cmd    w_cmd;
    t_dp_status w_dp_status;

    ffa_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_dp_status (w_dp_status),
        .o_cmd       (w_cmd)
    );

    ffa_datapath #(
        .ARENA_BYTES  (ARENA_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_request_bytes  (i_request_bytes),
        .i_block_offset   (i_block_offset),
        .o_dp_status      (w_dp_status),
        .o_payload_offset (o_payload_offset),
        .o_status         (o_status)
    );

endmodule

### src/ffa_checker.sv
// Port-level checks of the arena allocator and their bind to the top level.
module ffa_checker
    import ffa_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic [REQ_W-1:0] o_payload_offset,
    input logic [ST_W-1:0]  o_status
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_OOM || o_status == ST_NO_FREE))
        else $error("undefined status code");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_payload_offset == '0)
        else $error("failed request carries a payload offset");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word right after reset");

endmodule

bind first_fit_arena_allocator_top ffa_checker u_ffa_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_payload_offset (o_payload_offset),
    .o_status         (o_status)
);

### tb/testbench.sv
// Testbench for the first-fit arena allocator: scoreboarded random and directed requests.
`timescale 1ns / 1ps

module testbench;
    import ffa_pkg::*;

    localparam int ARENA = ARENA_BYTES_DEF;
    localparam int HB    = HEADER_BYTES_DEF;
    localparam int LIMIT = 200000;

    typedef struct packed {
        logic [REQ_W-1:0] offset;
        logic [ST_W-1:0]  status;
    } t_reply;

    // Arena header model: one entry per byte offset, bit 16 = used, 15..0 = next.
    class arena_scoreboard;
        logic [HDR_W-1:0] hdr [ARENA];
        t_reply pending [$];
        int errors;
        int live [$];   // payload offsets currently allocated
        int n_ok, n_oom, n_nofree;

        function new();
            foreach (hdr[i]) hdr[i] = '0;
            errors = 0; n_ok = 0; n_oom = 0; n_nofree = 0;
        endfunction

        function int nxt(int at);
            return at < ARENA ? int'(hdr[at][LINK_W-1:0]) : 0;
        endfunction

        function bit taken(int at);
            return at < ARENA && hdr[at][LINK_W];
        endfunction

        function void put(int at, int link, bit u);
            if (at < ARENA) hdr[at] = {u, link[LINK_W-1:0]};
        endfunction

        function logic [ST_W-1:0] allocate(int size, output int pay);
            int cur, nx, after, room, mid, tl;
            cur = 0;
            pay = 0;
            if (nxt(0) == 0) begin
                tl = 2 * HB + size;
                if (tl + HB > ARENA) return ST_OOM;
                put(0, HB, 0);
                put(HB, tl, 1);
                put(tl, 0, 0);
                pay = 2 * HB;
                return ST_OK;
            end
            forever begin
                nx = nxt(cur);
                if (nx == 0 || nx <= cur) return ST_OOM;
                cur = nx;
                if (taken(cur)) continue;
                after = nxt(cur);
                if (after != 0 && after > cur) begin
                    room = after >= cur + HB ? after - cur - HB : 0;
                    if (room >= size) begin
                        if (room - size > HB) begin
                            mid = cur + HB + size;
                            put(mid, after, 0);
                            put(cur, mid, 1);
                        end else begin
                            put(cur, after, 1);
                        end
                        pay = cur + HB;
                        return ST_OK;
                    end
                end else if (after == 0) begin
                    tl = cur + HB + size;
                    if (tl + HB > ARENA) return ST_OOM;
                    put(cur, tl, 1);
                    put(tl, 0, 0);
                    pay = cur + HB;
                    return ST_OK;
                end else begin
                    return ST_OOM;
                end
            end
        endfunction

        function void coalesce();
            int cur, n, nn;
            cur = 0;
            forever begin
                n = nxt(cur);
                if (n == 0 || n <= cur) return;
                cur = n;
                forever begin
                    n = nxt(cur);
                    if (n == 0 || n <= cur) break;
                    if (taken(cur) || taken(n)) break;
                    nn = nxt(n);
                    if (nn == 0) begin
                        put(cur, 0, 0);
                        return;
                    end
                    if (nn <= n) break;
                    put(cur, nn, 0);
                end
            end
        endfunction

        function logic [ST_W-1:0] release_block(int off);
            int cur, nx;
            bit hit;
            cur = 0;
            hit = 0;
            forever begin
                nx = nxt(cur);
                if (nx == 0 || nx <= cur) break;
                cur = nx;
                if (taken(cur) && cur + HB == off) begin
                    put(cur, nxt(cur), 0);
                    hit = 1;
                    break;
                end
            end
            coalesce();
            return hit ? ST_OK : ST_NO_FREE;
        endfunction

        function void note_request(bit cmd, int size, int off);
            t_reply r;
            int pay;
            if (cmd == 1'b0) begin
                r.status = allocate(size, pay);
                if (r.status == ST_OK) live.push_back(pay);
            end else begin
                r.status = release_block(off);
                foreach (live[i]) if (live[i] == off && r.status == ST_OK) begin
                    live.delete(i);
                    break;
                end
            end
            if (r.status != ST_OK) pay = 0;
            r.offset = pay[REQ_W-1:0];
            case (r.status)
                ST_OK:   n_ok++;
                ST_OOM:  n_oom++;
                default: n_nofree++;
            endcase
            pending.push_back(r);
        endfunction

        function void check_reply(logic [REQ_W-1:0] offset, logic [ST_W-1:0] status);
            t_reply e;
            if (pending.size() == 0) begin
                $error("unexpected word: payload_offset %0d status %0d", offset, status);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (offset !== e.offset) begin
                $error("payload_offset: expected %0d, got %0d", e.offset, offset);
                errors++;
            end
            if (status !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, status);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    logic             i_command = 1'b0;
    logic [REQ_W-1:0] i_request_bytes = '0;
    logic [REQ_W-1:0] i_block_offset = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic [REQ_W-1:0] o_payload_offset;
    logic [ST_W-1:0]  o_status;

    arena_scoreboard sb = new();
    int idle_cycles = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    first_fit_arena_allocator_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_request_bytes (i_request_bytes),
        .i_block_offset  (i_block_offset),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_payload_offset(o_payload_offset),
        .o_status        (o_status)
    );

    // Sample both handshakes at the rising edge; watchdog counts silent cycles.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                sb.note_request(i_command, i_request_bytes, i_block_offset);
            if (o_out_valid && i_out_ready)
                sb.check_reply(o_payload_offset, o_status);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Result side: random stall per word, occasionally none for long stretches.
    initial begin : drain
        int gap;
        bit burst;
        burst = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 99) < 3) burst = ~burst;
            gap = burst ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic send(bit cmd, int size, int off, int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_command       <= cmd;
        i_request_bytes <= size[REQ_W-1:0];
        i_block_offset  <= off[REQ_W-1:0];
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    function automatic int pick_live();
        return sb.live.size() ? sb.live[$urandom_range(0, sb.live.size() - 1)] : 0;
    endfunction

    initial begin : stimulus
        int gap, sz, k;
        bit burst;
        burst = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-chain first alloc, zero size, overflow, bad frees, split, merge.
        send(1, 0, 24, 0);            // free on empty chain
        send(0, 4095, 0, 0);          // tail overflow on empty chain
        send(0, 0, 0, 0);             // zero-byte block
        send(0, 100, 0, 1);
        send(0, 200, 0, 0);
        send(0, 40, 0, 2);
        send(1, 0, 4095, 0);          // unknown offset
        send(1, 0, 24 + 12, 0);       // free middle block
        send(0, 50, 0, 0);            // split of freed block
        send(0, 30, 0, 0);
        send(1, 0, 48, 0);
        send(1, 0, pick_live(), 3);
        send(1, 0, pick_live(), 0);
        send(0, 4000, 0, 0);          // no fit
        send(0, 3000, 0, 0);
        send(0, 2000, 0, 0);
        for (k = 0; k < 6; k++) send(1, 0, pick_live(), 0);  // merge down to tail
        send(0, 4095, 4095, 0);
        send(1, 4095, 0, 0);
        send(0, 12, 0, 0);

        for (k = 0; k < 1230; k++) begin
            if ($urandom_range(0, 99) < 3) burst = ~burst;
            gap = burst ? 0 : $urandom_range(0, 7);
            case ($urandom_range(0, 19))
                0:       send(1, $urandom, $urandom, gap);               // noise free
                1:       send(0, $urandom_range(0, 4095), $urandom, gap); // any size
                2, 3, 4, 5, 6, 7, 8:
                    send(1, $urandom, pick_live(), gap);
                default: begin
                    sz = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 600)
                                                     : $urandom_range(0, 64);
                    send(0, sz, $urandom, gap);
                end
            endcase
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);

        $display("Covered %0d ok, %0d out-of-memory and %0d missed-free replies.",
                 sb.n_ok, sb.n_oom, sb.n_nofree);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            if (sb.pending.size() != 0) $error("%0d words never arrived", sb.pending.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### files.f
src/ffa_pkg.sv
src/ffa_datapath.sv
src/ffa_controller.sv
src/first_fit_arena_allocator_top.sv
src/ffa_checker.sv
tb/testbench.sv
